// File: rtl/core/ssid_pkg.sv
package ssid_pkg;

  localparam int FUNC_W  = 2;
  localparam int ELEM_W  = 32;
  localparam int COUNT_W = 6;

  localparam logic [FUNC_W-1:0] OP_INSERT = 2'd0;
  localparam logic [FUNC_W-1:0] OP_DELETE = 2'd1;
  localparam logic [FUNC_W-1:0] OP_REPORT = 2'd2;

  typedef struct packed {
    logic lt;
    logic eq;
  } cmp_res_t;

endpackage

// File: rtl/core/ssid_ram.sv
module ssid_ram #(
  parameter int DEPTH = 32,
  parameter int WIDTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// File: rtl/core/ssid_cmp.sv
module ssid_cmp
  import ssid_pkg::*;
#(
  parameter int WIDTH = 32
) (
  input  logic signed [WIDTH-1:0] a,
  input  logic signed [WIDTH-1:0] b,
  output cmp_res_t                res
);

  assign res.lt = (a < b);
  assign res.eq = (a == b);

endmodule

// File: rtl/core/ssid_ctrl.sv
module ssid_ctrl
  import ssid_pkg::*;
#(
  parameter int CAPACITY    = 32,
  parameter int VALUE_WIDTH = 32
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [FUNC_W-1:0]              in_func,
  input  logic signed [ELEM_W-1:0]       in_value,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [ELEM_W-1:0]              out_element,
  output logic                           out_element_valid,
  output logic [COUNT_W-1:0]             out_count,
  output logic                           out_dropped,
  output logic                           out_last,
  output logic                           mem_we,
  output logic [$clog2(CAPACITY)-1:0]    mem_waddr,
  output logic [VALUE_WIDTH-1:0]         mem_wdata,
  output logic [$clog2(CAPACITY)-1:0]    mem_raddr,
  input  logic signed [VALUE_WIDTH-1:0]  mem_rdata,
  output logic signed [VALUE_WIDTH-1:0]  cmp_a,
  output logic signed [VALUE_WIDTH-1:0]  cmp_b,
  input  cmp_res_t                       cmp_res
);

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam logic [CW-1:0] CAP = CW'(CAPACITY);
  localparam logic [CW-1:0] ONE = CW'(1);

  typedef enum logic [10:0] {
    S_IDLE     = 11'b00000000001,
    S_SRCH_RD  = 11'b00000000010,
    S_SRCH_CMP = 11'b00000000100,
    S_DECIDE   = 11'b00000001000,
    S_SHUP_RD  = 11'b00000010000,
    S_SHUP_WR  = 11'b00000100000,
    S_INS_WR   = 11'b00001000000,
    S_SHDN_RD  = 11'b00010000000,
    S_SHDN_WR  = 11'b00100000000,
    S_EMIT_RD  = 11'b01000000000,
    S_EMIT_LD  = 11'b10000000000
  } state_t;

  state_t                   state;
  logic [CW-1:0]            idx;
  logic [CW-1:0]            pos;
  logic [CW-1:0]            cnt;
  logic [FUNC_W-1:0]        func_r;
  logic signed [VALUE_WIDTH-1:0] x;
  logic                     found;
  logic                     drop;
  logic                     load;
  logic                     emit_last;
  logic [CW-1:0]            idx_inc;
  logic [CW-1:0]            idx_inc2;

  assign in_ready  = (state == S_IDLE);
  assign idx_inc   = idx + ONE;
  assign idx_inc2  = idx + CW'(2);
  assign load      = (state == S_EMIT_LD) && (!out_valid || out_ready);
  assign emit_last = (cnt == '0) || (idx_inc == cnt);

  assign cmp_a = mem_rdata;
  assign cmp_b = x;

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = idx[AW-1:0];
    mem_wdata = mem_rdata;
    mem_raddr = idx[AW-1:0];
    unique case (state)
      S_SHDN_RD: begin
        mem_raddr = idx_inc[AW-1:0];
      end
      S_SHUP_WR: begin
        mem_we    = 1'b1;
        mem_waddr = idx_inc[AW-1:0];
      end
      S_SHDN_WR: begin
        mem_we = 1'b1;
      end
      S_INS_WR: begin
        mem_we    = 1'b1;
        mem_waddr = pos[AW-1:0];
        mem_wdata = x;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt   <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            func_r <= in_func;
            x      <= VALUE_WIDTH'(in_value);
            drop   <= 1'b0;
            found  <= 1'b0;
            idx    <= '0;
            state  <= (cnt == '0) ? S_DECIDE : S_SRCH_RD;
          end
        end
        S_SRCH_RD: begin
          state <= S_SRCH_CMP;
        end
        S_SRCH_CMP: begin
          if (cmp_res.lt) begin
            idx   <= idx_inc;
            state <= (idx_inc == cnt) ? S_DECIDE : S_SRCH_RD;
          end else begin
            found <= cmp_res.eq;
            state <= S_DECIDE;
          end
        end
        S_DECIDE: begin
          pos   <= idx;
          state <= S_EMIT_RD;
          if (func_r == OP_INSERT && !found) begin
            if (cnt == CAP) begin
              drop <= 1'b1;
              idx  <= '0;
            end else if (idx == cnt) begin
              state <= S_INS_WR;
            end else begin
              idx   <= cnt - ONE;
              state <= S_SHUP_RD;
            end
          end else if (func_r == OP_DELETE && found) begin
            if (idx_inc == cnt) begin
              cnt <= cnt - ONE;
              idx <= '0;
            end else begin
              state <= S_SHDN_RD;
            end
          end else begin
            idx <= '0;
          end
        end
        S_SHUP_RD: begin
          state <= S_SHUP_WR;
        end
        S_SHUP_WR: begin
          if (idx == pos) begin
            state <= S_INS_WR;
          end else begin
            idx   <= idx - ONE;
            state <= S_SHUP_RD;
          end
        end
        S_INS_WR: begin
          cnt   <= cnt + ONE;
          idx   <= '0;
          state <= S_EMIT_RD;
        end
        S_SHDN_RD: begin
          state <= S_SHDN_WR;
        end
        S_SHDN_WR: begin
          if (idx_inc2 == cnt) begin
            cnt   <= cnt - ONE;
            idx   <= '0;
            state <= S_EMIT_RD;
          end else begin
            idx   <= idx_inc;
            state <= S_SHDN_RD;
          end
        end
        S_EMIT_RD: begin
          state <= S_EMIT_LD;
        end
        S_EMIT_LD: begin
          if (load) begin
            idx   <= idx_inc;
            state <= emit_last ? S_IDLE : S_EMIT_RD;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // output register, frees the sequencer from the sink
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_element       <= (cnt == '0) ? '0 : ELEM_W'(mem_rdata);
      out_element_valid <= (cnt != '0);
      out_count         <= COUNT_W'(cnt);
      out_dropped       <= drop;
      out_last          <= emit_last;
    end
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (rst) cnt <= CAP)
    else $error("stored count above capacity");

  a_drop_full: assert property (@(posedge clk) disable iff (rst)
    (load && drop) |-> (cnt == CAP))
    else $error("drop flagged while set not full");

  a_last_idle: assert property (@(posedge clk) disable iff (rst)
    (load && emit_last) |=> (state == S_IDLE))
    else $error("final beat not followed by idle");

  a_shift_room: assert property (@(posedge clk) disable iff (rst)
    (state == S_SHUP_RD || state == S_INS_WR) |-> (cnt < CAP))
    else $error("insert shift with full set");

  a_shdn_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_SHDN_WR) |-> (idx_inc < cnt))
    else $error("delete shift past end");

endmodule

// File: rtl/core/sorted_unique_set_insert_delete.sv
// Sorted set of up to CAPACITY distinct signed values. Each input beat
// (tuser = func: 0 insert, 1 delete, 2 or 3 report only; tdata = value) is
// followed by a run of output beats listing the whole set in ascending order,
// one per value, tlast on the final beat; an empty set gives a single beat
// with element_valid low. A new value offered to a full set is refused and
// dropped is set on every beat of that run. One RAM with a write port and a
// registered read port, and one comparator, do all the work. An operation compares
// stored entries in ascending order until one is not below the value, shifts the
// entries above the position one at a time for an insert or delete, writes the
// inserted value, then reads the set out one entry per beat; the sink may stall any
// waiting beat by holding m_tready low. s_tready is high only between operations;
// the final output beat may still be waiting.
module sorted_unique_set_insert_delete
  import ssid_pkg::*;
#(
  parameter int CAPACITY    = 32,
  parameter int VALUE_WIDTH = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // [31:0] value
  input  logic [1:0]  s_tuser,   // [1:0] func
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,   // [31:0] element, [37:32] count, [39:38] zero
  output logic [1:0]  m_tuser,   // [0] element_valid, [1] dropped
  output logic        m_tlast
);

  localparam int AW = $clog2(CAPACITY);

  logic                          mem_we;
  logic [AW-1:0]                 mem_waddr;
  logic [VALUE_WIDTH-1:0]        mem_wdata;
  logic [AW-1:0]                 mem_raddr;
  logic [VALUE_WIDTH-1:0]        mem_rdata;
  logic signed [VALUE_WIDTH-1:0] cmp_a;
  logic signed [VALUE_WIDTH-1:0] cmp_b;
  cmp_res_t                      cmp_res;
  logic [ELEM_W-1:0]             element;
  logic                          element_valid;
  logic [COUNT_W-1:0]            count;
  logic                          dropped;

  ssid_ram #(
    .DEPTH (CAPACITY),
    .WIDTH (VALUE_WIDTH)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  ssid_cmp #(
    .WIDTH (VALUE_WIDTH)
  ) u_cmp (
    .a   (cmp_a),
    .b   (cmp_b),
    .res (cmp_res)
  );

  ssid_ctrl #(
    .CAPACITY    (CAPACITY),
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_ctrl (
    .clk               (clk),
    .rst               (rst),
    .in_valid          (s_tvalid),
    .in_ready          (s_tready),
    .in_func           (s_tuser),
    .in_value          (s_tdata),
    .out_valid         (m_tvalid),
    .out_ready         (m_tready),
    .out_element       (element),
    .out_element_valid (element_valid),
    .out_count         (count),
    .out_dropped       (dropped),
    .out_last          (m_tlast),
    .mem_we            (mem_we),
    .mem_waddr         (mem_waddr),
    .mem_wdata         (mem_wdata),
    .mem_raddr         (mem_raddr),
    .mem_rdata         (mem_rdata),
    .cmp_a             (cmp_a),
    .cmp_b             (cmp_b),
    .cmp_res           (cmp_res)
  );

  assign m_tdata = {2'b00, count, element};
  assign m_tuser = {dropped, element_valid};

endmodule

// File: sim/tb_sorted_unique_set_insert_delete.sv
module tb_sorted_unique_set_insert_delete
  import ssid_pkg::*;
();

  localparam int CAPACITY      = 32;
  localparam int PHASE_OPS     = 86;
  localparam int SETTLE_CYCLES = 400;
  localparam int CYCLE_LIMIT   = 1_000_000;
  localparam logic [FUNC_W-1:0] OP_SPARE = 2'd3;

  typedef struct packed {
    logic [ELEM_W-1:0]  element;
    logic               valid;
    logic [COUNT_W-1:0] count;
    logic               dropped;
    logic               last;
  } listing_beat_t;

  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic [31:0]       value;
    logic              typed;
    listing_beat_t     beat;
  } dir_row_t;

  localparam listing_beat_t EMPTY_BEAT = '{32'h0, 1'b0, 6'd0, 1'b0, 1'b1};
  localparam int N_DIR = 22;

  // typed rows carry their single expected beat; the rest go through the predictor
  localparam dir_row_t DIR_TAB [N_DIR] = '{
    '{OP_REPORT, 32'h0000_0000, 1'b1, EMPTY_BEAT},
    '{OP_DELETE, 32'h0000_0005, 1'b1, EMPTY_BEAT},
    '{OP_INSERT, 32'h7FFF_FFFF, 1'b1, '{32'h7FFF_FFFF, 1'b1, 6'd1, 1'b0, 1'b1}},
    '{OP_DELETE, 32'h7FFF_FFFF, 1'b1, EMPTY_BEAT},
    '{OP_INSERT, 32'h8000_0000, 1'b1, '{32'h8000_0000, 1'b1, 6'd1, 1'b0, 1'b1}},
    '{OP_INSERT, 32'h7FFF_FFFF, 1'b0, EMPTY_BEAT},
    '{OP_INSERT, 32'h0000_0000, 1'b0, EMPTY_BEAT},
    '{OP_INSERT, 32'h0000_0000, 1'b0, EMPTY_BEAT},
    '{OP_INSERT, 32'hFFFF_FFFF, 1'b0, EMPTY_BEAT},
    '{OP_INSERT, 32'h0000_0001, 1'b0, EMPTY_BEAT},
    '{OP_SPARE,  32'hA5A5_A5A5, 1'b0, EMPTY_BEAT},
    '{OP_DELETE, 32'h0000_3039, 1'b0, EMPTY_BEAT},
    '{OP_DELETE, 32'h0000_0000, 1'b0, EMPTY_BEAT},
    '{OP_DELETE, 32'h8000_0000, 1'b0, EMPTY_BEAT},
    '{OP_DELETE, 32'h7FFF_FFFF, 1'b0, EMPTY_BEAT},
    '{OP_REPORT, 32'h5A5A_5A5A, 1'b0, EMPTY_BEAT},
    '{OP_INSERT, 32'h5555_5555, 1'b0, EMPTY_BEAT},
    '{OP_INSERT, 32'hAAAA_AAAA, 1'b0, EMPTY_BEAT},
    '{OP_DELETE, 32'hFFFF_FFFF, 1'b0, EMPTY_BEAT},
    '{OP_DELETE, 32'h0000_0001, 1'b0, EMPTY_BEAT},
    '{OP_DELETE, 32'h5555_5555, 1'b0, EMPTY_BEAT},
    '{OP_DELETE, 32'hAAAA_AAAA, 1'b1, EMPTY_BEAT}
  };

  logic        clk      = 1'b0;
  logic        rst      = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [31:0] s_tdata  = '0;
  logic [1:0]  s_tuser  = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [39:0] m_tdata;
  logic [1:0]  m_tuser;
  logic        m_tlast;

  logic signed [31:0] set_q[$];
  listing_beat_t      listing_q[$];
  int                 src_idle_pct;
  int                 snk_stall_pct;
  int                 n_ops;
  int                 n_beats;
  int                 n_drops;
  int                 n_fulls;
  int                 n_fail;
  int unsigned        cycle_cnt;

  always #2 clk = ~clk;

  sorted_unique_set_insert_delete #(
    .CAPACITY(CAPACITY)
  ) u_dut (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .s_tuser(s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),
    .m_tuser(m_tuser),
    .m_tlast(m_tlast)
  );

  // applies one operation to the shadow set and queues the listing it produces
  task automatic predict_listing(input logic [1:0] f, input logic [31:0] v, input bit push);
    logic signed [31:0] x;
    int                 pos;
    bit                 found;
    bit                 drop;
    listing_beat_t      b;
    x    = v;
    pos  = 0;
    drop = 1'b0;
    while (pos < set_q.size() && set_q[pos] < x) pos++;
    found = (pos < set_q.size()) && (set_q[pos] == x);
    if (f == OP_INSERT && !found) begin
      if (set_q.size() >= CAPACITY) drop = 1'b1;
      else set_q.insert(pos, x);
    end else if (f == OP_DELETE && found) begin
      set_q.delete(pos);
    end
    n_drops += drop;
    if (set_q.size() == CAPACITY) n_fulls++;
    if (!push) return;
    if (set_q.size() == 0) begin
      b = EMPTY_BEAT;
      b.dropped = drop;
      listing_q.push_back(b);
    end
    foreach (set_q[k]) begin
      b.element = set_q[k];
      b.valid   = 1'b1;
      b.count   = COUNT_W'(set_q.size());
      b.dropped = drop;
      b.last    = (k == set_q.size() - 1);
      listing_q.push_back(b);
    end
  endtask

  // entered and left at a falling edge
  task automatic send_op(input logic [1:0] f, input logic [31:0] v, input bit typed = 1'b0,
                         input listing_beat_t typed_beat = EMPTY_BEAT);
    while ($urandom_range(99) < src_idle_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= f;
    s_tdata  <= v;
    do @(posedge clk); while (!s_tready);
    predict_listing(f, v, !typed);
    if (typed) listing_q.push_back(typed_beat);
    n_ops++;
    @(negedge clk);
  endtask

  function automatic logic [31:0] pick_present();
    if (set_q.size() == 0) return $urandom();
    return set_q[$urandom_range(set_q.size() - 1)];
  endfunction

  // fill to capacity, push past it, drain down to two entries, then free mix
  task automatic run_phase(input int src_pct, input int snk_pct);
    int n;
    int r;
    n = 0;
    src_idle_pct  = src_pct;
    snk_stall_pct = snk_pct;
    while (set_q.size() < CAPACITY) begin
      r = $urandom_range(9);
      if (r < 8) send_op(OP_INSERT, $urandom());
      else if (r == 8) send_op(OP_INSERT, pick_present());
      else send_op($urandom_range(1) ? OP_REPORT : OP_SPARE, $urandom());
      n++;
    end
    repeat (6) begin
      send_op(OP_INSERT, $urandom_range(1) ? pick_present() : $urandom());
      n++;
    end
    while (set_q.size() > 2) begin
      r = $urandom_range(9);
      if (r < 8) send_op(OP_DELETE, pick_present());
      else if (r == 8) send_op(OP_DELETE, $urandom());
      else send_op(OP_REPORT, $urandom());
      n++;
    end
    while (n < PHASE_OPS) begin
      r = $urandom_range(9);
      if (r < 3) send_op(FUNC_W'($urandom_range(3)), pick_present());
      else if (r < 6) send_op(FUNC_W'($urandom_range(3)), $urandom());
      else send_op(FUNC_W'($urandom_range(3)), int'($urandom_range(16)) - 8);
      n++;
    end
  endtask

  always @(negedge clk) begin
    m_tready <= ($urandom_range(99) >= snk_stall_pct);
  end

  always @(posedge clk) begin
    listing_beat_t want;
    if (!rst && m_tvalid && m_tready) begin
      n_beats++;
      if (listing_q.size() == 0) begin
        $error("unexpected beat: element %h", m_tdata[31:0]);
        n_fail++;
      end else begin
        want = listing_q.pop_front();
        if (m_tdata[31:0] !== want.element) begin
          $error("element: expected %h, got %h", want.element, m_tdata[31:0]);
          n_fail++;
        end
        if (m_tuser[0] !== want.valid) begin
          $error("element_valid: expected %b, got %b", want.valid, m_tuser[0]);
          n_fail++;
        end
        if (m_tdata[37:32] !== want.count) begin
          $error("count: expected %0d, got %0d", want.count, m_tdata[37:32]);
          n_fail++;
        end
        if (m_tuser[1] !== want.dropped) begin
          $error("dropped: expected %b, got %b", want.dropped, m_tuser[1]);
          n_fail++;
        end
        if (m_tlast !== want.last) begin
          $error("last: expected %b, got %b", want.last, m_tlast);
          n_fail++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d beats outstanding", cycle_cnt, listing_q.size());
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin
    src_idle_pct  = 7;
    snk_stall_pct = 85;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    foreach (DIR_TAB[i])
      send_op(DIR_TAB[i].func, DIR_TAB[i].value, DIR_TAB[i].typed, DIR_TAB[i].beat);
    run_phase(7, 85);
    run_phase(85, 7);
    run_phase(0, 0);
    s_tvalid <= 1'b0;
    while (listing_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("%0d operations sent, %0d listing beats checked, %0d mismatches",
             n_ops, n_beats, n_fail);
    $display("set at capacity after %0d operations, %0d inserts refused as full",
             n_fulls, n_drops);
    if (n_fail == 0) $display("*** PASSED ***");
    else $display("*** FAILED ***");
    $finish;
  end

endmodule
